// ===== src/http_request_line_parser_unit_macros.svh =====
// Assertion macros for the HTTP request line parser.
`ifndef HTTP_REQUEST_LINE_PARSER_UNIT_MACROS_SVH
`define HTTP_REQUEST_LINE_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define HRLP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hrlp assertion failed");

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define HRLP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hrlp assertion failed");

`endif

// ===== src/hrlp_pkg.sv =====
// Types, codes and character constants of the HTTP request line parser.
`default_nettype none

package hrlp_pkg;

	typedef enum logic [3:0] {
		PH_METHOD    = 4'd0,
		PH_PATH      = 4'd1,
		PH_LIT_H     = 4'd2,
		PH_LIT_T1    = 4'd3,
		PH_LIT_T2    = 4'd4,
		PH_LIT_P     = 4'd5,
		PH_LIT_SLASH = 4'd6,
		PH_LIT_ONE   = 4'd7,
		PH_LIT_DOT   = 4'd8,
		PH_DIGIT     = 4'd9,
		PH_DONE      = 4'd10
	} phase_t;

	localparam logic [3:0] ERR_NONE         = 4'd0;
	localparam logic [3:0] ERR_EMPTY_METHOD = 4'd1;
	localparam logic [3:0] ERR_METHOD_SPACE = 4'd2;
	localparam logic [3:0] ERR_EMPTY_PATH   = 4'd3;
	localparam logic [3:0] ERR_PATH_SPACE   = 4'd4;
	localparam logic [3:0] ERR_LIT_BASE     = 4'd5;
	localparam logic [3:0] ERR_LIT_DIGIT    = 4'd12;
	localparam logic [3:0] ERR_PAST_END     = 4'd13;

	localparam logic [1:0] KIND_METHOD = 2'd0;
	localparam logic [1:0] KIND_PATH   = 2'd1;
	localparam logic [1:0] KIND_FIXED  = 2'd2;
	localparam logic [1:0] KIND_REJECT = 2'd3;

	localparam logic [3:0] VER_BASE = 4'd10;
	localparam logic [3:0] VER_1_0  = 4'd10;
	localparam logic [3:0] VER_1_1  = 4'd11;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;

	typedef struct packed {
		logic [7:0] byte_in;
	} in_word_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] error_code;
		logic [1:0] char_kind;
		logic [7:0] char_value;
		logic [3:0] version;
		logic       complete;
	} out_word_t;

	typedef struct packed {
		phase_t     phase;
		logic       method_seen;
		logic       path_seen;
		logic [3:0] parsed_version;
		logic [3:0] sticky_error;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:          PH_METHOD,
		method_seen:    1'b0,
		path_seen:      1'b0,
		parsed_version: 4'd0,
		sticky_error:   ERR_NONE
	};

	function automatic logic is_letter(input logic [7:0] b);
		return ((b >= CH_UP_A) && (b <= CH_UP_Z)) || ((b >= CH_LO_A) && (b <= CH_LO_Z));
	endfunction

	// expected character at each fixed-text position before the digit
	function automatic logic [7:0] lit_char(input phase_t ph);
		logic [7:0] c;
		case (ph)
			PH_LIT_H:     c = CH_H;
			PH_LIT_T1:    c = CH_T;
			PH_LIT_T2:    c = CH_T;
			PH_LIT_P:     c = CH_P;
			PH_LIT_SLASH: c = CH_SLASH;
			PH_LIT_ONE:   c = CH_ONE;
			PH_LIT_DOT:   c = CH_DOT;
			default:      c = CH_H;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== src/hrlp_stream_if.sv =====
// Valid/ready stream interface used for the byte and result channels.
`default_nettype none

interface hrlp_stream_if #(parameter type T = logic [7:0]) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/http_request_line_parser_unit.sv =====
// Top level of the HTTP request line parser: byte register, decode, result register.
// Usage:
//   rx carries one byte of a request line per word (METHOD SP PATH SP HTTP/1.x).
//   tx returns exactly one result word per byte: ok, error_code, char_kind,
//   the echoed byte, the version parsed so far and the complete flag.
//   Method and path bytes come back tagged so downstream logic can keep them.
// Timing:
//   A byte taken from rx sits in the input register, is decoded against the
//   parser state and lands in the result register once that register is free;
//   tx takes it from there. One byte per cycle sustained while tx takes results:
//   the decode is a single phase compare and transition between the two
//   registers, and the state updates in the same cycle the byte moves on.
// Stalls:
//   While tx is stalled the result register holds and the input register still
//   takes one more byte; rx.ready drops only when both registers are full.
// Reset:
//   arst_n low empties both registers and returns the parser to the method
//   phase with no error and version 0. Errors stick until reset.
`default_nettype none
`include "http_request_line_parser_unit_macros.svh"

module http_request_line_parser_unit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	hrlp_stream_if.sink          rx,
	hrlp_stream_if.source        tx
);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// result stage
	logic                valid_s2;
	hrlp_pkg::out_word_t res_s2;

	// parser state
	hrlp_pkg::state_t    state_q;
	hrlp_pkg::state_t    state_nxt;
	hrlp_pkg::out_word_t res_nxt;

	logic s2_free;
	logic adv_s1;
	logic rx_take;

	assign s2_free = !valid_s2 || tx.ready;
	assign adv_s1  = valid_s1 && s2_free;
	assign rx.ready = !valid_s1 || adv_s1;
	assign rx_take = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_take) begin
			byte_s1 <= rx.data.byte_in;
		end
	end

	hrlp_step u_step (
		.cur     (state_q),
		.byte_in (byte_s1),
		.nxt     (state_nxt),
		.res     (res_nxt)
	);

	// state moves only when the decoded byte is handed to the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hrlp_pkg::STATE_RESET;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (tx.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign tx.valid = valid_s2;
	assign tx.data  = res_s2;

	// a recorded error never changes
	`HRLP_ASSERT_NEXT(a_sticky_hold, state_q.sticky_error != hrlp_pkg::ERR_NONE, state_q.sticky_error == $past(state_q.sticky_error))
	// ok and error code agree, and accepted bytes are never tagged rejected
	`HRLP_ASSERT_NOW(a_ok_code, valid_s2, res_s2.ok == (res_s2.error_code == hrlp_pkg::ERR_NONE) && (res_s2.ok == (res_s2.char_kind != hrlp_pkg::KIND_REJECT)))
	// a completed line carries a valid version
	`HRLP_ASSERT_NOW(a_complete_ver, valid_s2 && res_s2.complete, res_s2.version == hrlp_pkg::VER_1_0 || res_s2.version == hrlp_pkg::VER_1_1)
	// backpressure only when both stages are full and tx stalls
	`HRLP_ASSERT_NOW(a_ready_full, !rx.ready, valid_s1 && valid_s2 && !tx.ready)

endmodule

`default_nettype wire

// ===== src/hrlp_step.sv =====
// Per-byte decode: parser state and one byte in, next state and result word out.
`default_nettype none

module hrlp_step (
	input  var hrlp_pkg::state_t    cur,
	input  var logic [7:0]          byte_in,
	output var hrlp_pkg::state_t    nxt,
	output var hrlp_pkg::out_word_t res
);

	typedef struct packed {
		logic [3:0] err;
		logic [1:0] kind;
		logic       set_method;
		logic       set_path;
		logic       advance;
		logic       to_path;
		logic       to_lit;
		logic       take_digit;
	} dec_t;

	dec_t dec;
	logic letter;

	assign letter = hrlp_pkg::is_letter(byte_in);

	// classify the byte against the current phase
	always_comb begin
		dec = '0;
		dec.err = hrlp_pkg::ERR_NONE;
		dec.kind = hrlp_pkg::KIND_FIXED;
		if (cur.sticky_error != hrlp_pkg::ERR_NONE) begin
			dec.err = cur.sticky_error;
		end else begin
			case (cur.phase)
				hrlp_pkg::PH_METHOD: begin
					if (letter) begin
						dec.set_method = 1'b1;
						dec.kind = hrlp_pkg::KIND_METHOD;
					end else if (!cur.method_seen) begin
						dec.err = hrlp_pkg::ERR_EMPTY_METHOD;
					end else if (byte_in == hrlp_pkg::CH_SPACE) begin
						dec.to_path = 1'b1;
					end else begin
						dec.err = hrlp_pkg::ERR_METHOD_SPACE;
					end
				end
				hrlp_pkg::PH_PATH: begin
					if (letter || (byte_in == hrlp_pkg::CH_SLASH)) begin
						dec.set_path = 1'b1;
						dec.kind = hrlp_pkg::KIND_PATH;
					end else if (!cur.path_seen) begin
						dec.err = hrlp_pkg::ERR_EMPTY_PATH;
					end else if (byte_in == hrlp_pkg::CH_SPACE) begin
						dec.to_lit = 1'b1;
					end else begin
						dec.err = hrlp_pkg::ERR_PATH_SPACE;
					end
				end
				hrlp_pkg::PH_LIT_H, hrlp_pkg::PH_LIT_T1, hrlp_pkg::PH_LIT_T2,
				hrlp_pkg::PH_LIT_P, hrlp_pkg::PH_LIT_SLASH, hrlp_pkg::PH_LIT_ONE,
				hrlp_pkg::PH_LIT_DOT: begin
					if (byte_in == hrlp_pkg::lit_char(cur.phase)) begin
						dec.advance = 1'b1;
					end else begin
						dec.err = 4'(hrlp_pkg::ERR_LIT_BASE
							+ 4'(cur.phase - hrlp_pkg::PH_LIT_H));
					end
				end
				hrlp_pkg::PH_DIGIT: begin
					if (byte_in inside {hrlp_pkg::CH_ZERO, hrlp_pkg::CH_ONE}) begin
						dec.take_digit = 1'b1;
					end else begin
						dec.err = hrlp_pkg::ERR_LIT_DIGIT;
					end
				end
				default: begin
					// done, and the unreachable codes above it
					dec.err = hrlp_pkg::ERR_PAST_END;
				end
			endcase
		end
		if (dec.err != hrlp_pkg::ERR_NONE) begin
			dec.kind = hrlp_pkg::KIND_REJECT;
		end
	end

	// next state
	always_comb begin
		nxt = cur;
		if (dec.err != hrlp_pkg::ERR_NONE) begin
			nxt.sticky_error = dec.err;
		end
		if (dec.set_method) begin
			nxt.method_seen = 1'b1;
		end
		if (dec.set_path) begin
			nxt.path_seen = 1'b1;
		end
		if (dec.to_path) begin
			nxt.phase = hrlp_pkg::PH_PATH;
		end
		if (dec.to_lit) begin
			nxt.phase = hrlp_pkg::PH_LIT_H;
		end
		if (dec.advance) begin
			nxt.phase = hrlp_pkg::phase_t'(4'(cur.phase + 4'd1));
		end
		if (dec.take_digit) begin
			nxt.phase = hrlp_pkg::PH_DONE;
			nxt.parsed_version = 4'(hrlp_pkg::VER_BASE + {3'b000, byte_in[0]});
		end
	end

	// result word
	always_comb begin
		res.ok = (dec.err == hrlp_pkg::ERR_NONE);
		res.error_code = dec.err;
		res.char_kind = dec.kind;
		res.char_value = byte_in;
		res.version = nxt.parsed_version;
		res.complete = (nxt.phase >= hrlp_pkg::PH_DONE);
	end

endmodule

`default_nettype wire
